// File: design/dq_pkg.sv
// Shared constants, types and helpers for the double-ended queue.
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH          = 256;
    localparam int WORD_BITS      = 32;
    localparam int COUNT_BITS     = $clog2(DEPTH + 1);
    localparam int DATA_BITS      = 32;
    localparam int OP_BITS        = 2;
    localparam int COUNT_OUT_BITS = 9;
    localparam int STATUS_BITS    = 2;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_POP_EMPTY,
        ST_PUSH_FULL
    } status_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic  en;
        op_t   op;
        word_t word;
    } cell_ctrl_t;

    // What a cell shows its neighbours: occupancy, the front-ordered word
    // and the back-ordered word.
    typedef struct packed {
        logic  occ;
        word_t a;
        word_t b;
    } cell_link_t;

    function automatic word_t to_word(input logic signed [DATA_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(unsigned'(v));
        return w[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [DATA_BITS-1:0] to_data(input word_t v);
        logic [63:0] w;
        w = 64'(v);
        return signed'(w[DATA_BITS-1:0]);
    endfunction

endpackage

// File: design/dq_cmd_if.sv
// Command channel: operation and word to push.
`timescale 1ns / 1ps

interface dq_cmd_if
    import dq_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [OP_BITS-1:0]            op;
    logic signed [DATA_BITS-1:0]   push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink (input valid, input op, input push_value, output ready);
endinterface

// File: design/dq_rsp_if.sv
// Response channel: popped word, peeks, entry count and status.
`timescale 1ns / 1ps

interface dq_rsp_if
    import dq_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [DATA_BITS-1:0]   popped_value;
    logic signed [DATA_BITS-1:0]   front_value;
    logic signed [DATA_BITS-1:0]   back_value;
    logic [COUNT_OUT_BITS-1:0]     entry_count;
    logic [STATUS_BITS-1:0]        status;

    modport source (
        output valid, output popped_value, output front_value, output back_value,
        output entry_count, output status, input ready
    );
    modport sink (
        input valid, input popped_value, input front_value, input back_value,
        input entry_count, input status, output ready
    );
endinterface

// File: design/double_ended_queue_top.sv
// Top level of the double-ended queue: a row of shifting cells and the response register.
// Latency: the response to a command is valid on the cycle after the command transaction.
// Throughput: one command per cycle unless rsp stalls; the row shifts once per kept command.
// A new command is taken in the same cycle as the pending response transaction.
// Reset empties the queue at once (occupancy and count cleared); no clearing pass is needed.
`timescale 1ns / 1ps

module double_ended_queue_top
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dq_cmd_if.sink   cmd,
    dq_rsp_if.source rsp
);

    cell_link_t links [DEPTH];
    cell_link_t head_link;
    cell_link_t tail_link;
    cell_ctrl_t ctrl;
    logic [DEPTH-1:0] occ_vec;

    count_t  count_reg, count_next;
    logic    rsp_valid_reg;
    logic signed [DATA_BITS-1:0] popped_reg, popped_next;
    status_t status_reg, status_next;

    logic  cmd_acc;
    op_t   op;
    logic  is_push;
    logic  full;
    logic  empty;
    logic  err;
    word_t word;

    assign op      = op_t'(cmd.op);
    assign word    = to_word(cmd.push_value);
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_acc = cmd.valid && cmd.ready;
    assign is_push = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
    assign full    = (count_reg == COUNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign err     = is_push ? full : empty;

    assign ctrl = '{en: cmd_acc && !err, op: op, word: word};

    // Cell 0 sees the incoming word on its left; the far end sees an empty cell.
    assign head_link = '{occ: 1'b1, a: word, b: word};
    assign tail_link = '{occ: 1'b0, a: '0, b: '0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;

        if (i == 0)
        begin : g_first
            assign left_link = head_link;
        end
        else
        begin : g_inner_left
            assign left_link = links[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_link = tail_link;
        end
        else
        begin : g_inner_right
            assign right_link = links[i+1];
        end

        dq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .here  (links[i])
        );

        assign occ_vec[i] = links[i].occ;
    end

    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - COUNT_BITS'(1);
                    popped_next = to_data(links[0].a);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - COUNT_BITS'(1);
                    popped_next = to_data(links[0].b);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (cmd_acc)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            popped_reg <= popped_next;
        end
    end

    // The row only changes when a command is taken, which is also when the
    // pending response leaves, so the peeks come straight from cell 0.
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.front_value  = empty ? '0 : to_data(links[0].a);
    assign rsp.back_value   = empty ? '0 : to_data(links[0].b);
    assign rsp.entry_count  = COUNT_OUT_BITS'(count_reg);
    assign rsp.status       = status_reg;

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_occupancy_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & (occ_vec + DEPTH'(1))) == '0)
        else $error("occupied cells do not form a prefix of the row");

    a_push_full_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && is_push && full) |=> (status_reg == ST_PUSH_FULL) && $stable(count_reg))
        else $error("push on a full queue not dropped");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && !is_push && !empty) |=>
            (count_reg == $past(count_reg) - COUNT_BITS'(1)) && (status_reg == ST_OK))
        else $error("pop did not remove one entry");

endmodule

// File: design/dq_cell.sv
// One cell of the queue row: a front-ordered word, a back-ordered word and occupancy.
`timescale 1ns / 1ps

module dq_cell
    import dq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t here
);

    logic  occ_reg, occ_next;
    word_t a_reg, a_next;
    word_t b_reg, b_next;

    // Row a keeps the front at cell 0, row b keeps the back at cell 0.
    // The occupied cells always form a prefix, so the first free cell is
    // the one that is empty while its left neighbour is occupied.
    always_comb
    begin
        occ_next = occ_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                OP_PUSH_FRONT:
                begin
                    occ_next = left.occ;
                    a_next   = left.a;
                    if (!occ_reg && left.occ)
                    begin
                        b_next = ctrl.word;
                    end
                end
                OP_PUSH_BACK:
                begin
                    occ_next = left.occ;
                    b_next   = left.b;
                    if (!occ_reg && left.occ)
                    begin
                        a_next = ctrl.word;
                    end
                end
                OP_POP_FRONT:
                begin
                    occ_next = right.occ;
                    a_next   = right.a;
                end
                OP_POP_BACK:
                begin
                    occ_next = right.occ;
                    b_next   = right.b;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign here = '{occ: occ_reg, a: a_reg, b: b_reg};

endmodule

// File: tb/tb_double_ended_queue_top.sv
// Self-checking testbench for the double-ended queue top level.
`timescale 1ns / 1ps

module tb_double_ended_queue_top;
    import dq_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_REPORTS     = 40;

    typedef logic signed [DATA_BITS-1:0] data_t;

    typedef struct {
        data_t                     popped;
        data_t                     front;
        data_t                     back;
        logic [COUNT_OUT_BITS-1:0] count;
        status_t                   status;
    } dq_result_t;

    logic clk;
    logic rst_n;

    dq_cmd_if cmd_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the queue contents, kept as a ring unlike the block's shifting cells.
    word_t ring_words [DEPTH];
    int    head_slot;
    int    tail_slot;
    int    held_words;

    dq_result_t expected_results [$];

    int error_count;
    int commands_sent;
    int results_seen;
    int full_drops_seen;
    int empty_pops_seen;
    int idle_cycles;

    // Sender pacing and the receiver's long hold-off request.
    bit sender_gaps_on;
    int burst_left;
    int hold_request;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int slot_after(int s);
        return (s + 1) % DEPTH;
    endfunction

    function automatic int slot_before(int s);
        return (s + DEPTH - 1) % DEPTH;
    endfunction

    function automatic data_t word_as_data(word_t w);
        logic [63:0] wide;
        wide = 64'(w);
        return signed'(wide[DATA_BITS-1:0]);
    endfunction

    // Applies one operation to the shadow queue and returns the response it should give.
    function automatic dq_result_t apply_operation(op_t op, data_t value);
        dq_result_t r;
        word_t      w;
        w = word_t'(unsigned'(value));
        r.popped = '0;
        r.status = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (held_words >= DEPTH)
            begin
                r.status = ST_PUSH_FULL;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                head_slot = slot_before(head_slot);
                ring_words[head_slot] = w;
                held_words++;
            end
            else
            begin
                ring_words[tail_slot] = w;
                tail_slot = slot_after(tail_slot);
                held_words++;
            end
        end
        else
        begin
            if (held_words == 0)
            begin
                r.status = ST_POP_EMPTY;
            end
            else if (op == OP_POP_FRONT)
            begin
                r.popped = word_as_data(ring_words[head_slot]);
                head_slot = slot_after(head_slot);
                held_words--;
            end
            else
            begin
                tail_slot = slot_before(tail_slot);
                r.popped = word_as_data(ring_words[tail_slot]);
                held_words--;
            end
        end
        if (held_words != 0)
        begin
            r.front = word_as_data(ring_words[head_slot]);
            r.back  = word_as_data(ring_words[slot_before(tail_slot)]);
        end
        else
        begin
            r.front = '0;
            r.back  = '0;
        end
        r.count = COUNT_OUT_BITS'(held_words);
        return r;
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return data_t'($urandom);
        endcase
    endfunction

    // Offers one command and waits for its transaction; the expectation is
    // recorded at the edge where it is accepted.
    task automatic send_command(op_t op, data_t value);
        int gap;
        if (sender_gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 6);
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left--;
        end
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.push_value <= value;
        do @(posedge clk); while (!cmd_ch.ready);
        expected_results.push_back(apply_operation(op, value));
        commands_sent++;
    endtask

    task automatic release_command_channel();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
    endtask

    // Holds the sender back until every outstanding response has arrived.
    task automatic settle_queue();
        release_command_channel();
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_ends();
        send_command(OP_POP_FRONT, 32'sd5);
        send_command(OP_POP_BACK, -32'sd5);
        send_command(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_command(OP_PUSH_BACK, 32'sh8000_0000);
        send_command(OP_PUSH_FRONT, -32'sd1);
        send_command(OP_PUSH_BACK, 32'sd0);
        send_command(OP_PUSH_BACK, 32'sh5555_5555);
        send_command(OP_PUSH_FRONT, 32'shaaaa_aaaa);
        send_command(OP_POP_FRONT, 32'sd0);
        send_command(OP_POP_BACK, 32'sd0);
        send_command(OP_POP_FRONT, -32'sd1);
        send_command(OP_POP_BACK, -32'sd1);
        send_command(OP_POP_BACK, 32'sd0);
        send_command(OP_POP_FRONT, 32'sd0);
        send_command(OP_POP_BACK, 32'sd0);
        // A single stored word is both the front and the back.
        send_command(OP_PUSH_BACK, 32'sd1);
        send_command(OP_POP_FRONT, 32'sd0);
        send_command(OP_PUSH_FRONT, 32'sd2);
        send_command(OP_POP_BACK, 32'sd0);
        send_command(OP_POP_FRONT, 32'sd0);
        settle_queue();
    endtask

    task automatic test_fill_to_full();
        while (held_words < DEPTH)
            send_command(op_t'($urandom_range(0, 1)), pick_value());
        send_command(OP_PUSH_FRONT, pick_value());
        send_command(OP_PUSH_BACK, pick_value());
        send_command(op_t'($urandom_range(2, 3)), pick_value());
        send_command(op_t'($urandom_range(0, 1)), pick_value());
        send_command(OP_PUSH_BACK, pick_value());
        send_command(OP_PUSH_FRONT, pick_value());
        settle_queue();
    endtask

    task automatic test_drain_to_empty();
        while (held_words > 0)
            send_command(op_t'($urandom_range(2, 3)), pick_value());
        send_command(OP_POP_BACK, pick_value());
        send_command(OP_POP_FRONT, pick_value());
        settle_queue();
    endtask

    // The receiver holds off while commands keep coming, so the block must
    // stall its command channel.
    task automatic test_output_hold_off();
        sender_gaps_on = 1'b0;
        hold_request = 60;
        repeat (12) send_command(op_t'($urandom_range(0, 3)), pick_value());
        sender_gaps_on = 1'b1;
        settle_queue();
    endtask

    task automatic test_random_mix();
        int push_pct;
        int op_pick;
        for (int i = 0; i < 200; i++)
        begin
            if (i % 50 == 0)
            begin
                push_pct = 30 + 20 * $urandom_range(0, 2);
                sender_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < push_pct)
                op_pick = $urandom_range(0, 1);
            else
                op_pick = $urandom_range(2, 3);
            send_command(op_t'(op_pick), pick_value());
        end
        sender_gaps_on = 1'b1;
        settle_queue();
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        dq_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (rsp_ch.status == ST_PUSH_FULL) full_drops_seen++;
            if (rsp_ch.status == ST_POP_EMPTY) empty_pops_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: response with nothing outstanding: count %0d, status %0d",
                             $time, rsp_ch.entry_count, rsp_ch.status);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("popped_value", unsigned'(want.popped),
                            unsigned'(rsp_ch.popped_value));
                check_field("front_value", unsigned'(want.front),
                            unsigned'(rsp_ch.front_value));
                check_field("back_value", unsigned'(want.back),
                            unsigned'(rsp_ch.back_value));
                check_field("entry_count", want.count, rsp_ch.entry_count);
                check_field("status", want.status, rsp_ch.status);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("tb_double_ended_queue_top: errors");
                $finish;
            end
        end
    end

    // The receiver switches between stall patterns of its own, and takes a
    // long hold-off when one is requested.
    initial
    begin
        int stall_mode;
        int stall_phase;
        int hold_len;
        rsp_ch.ready = 1'b0;
        stall_mode = 0;
        stall_phase = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_len = hold_request;
                hold_request = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold_len - 1) @(negedge clk);
            end
            else
            begin
                if (stall_phase % 64 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 99) < 70);
                    2:       rsp_ch.ready <= (stall_phase % 4 != 3);
                    default: rsp_ch.ready <= ($urandom_range(0, 99) < 30);
                endcase
                stall_phase++;
            end
        end
    end

    initial
    begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_PUSH_FRONT;
        cmd_ch.push_value = '0;
        rst_n             = 1'b0;
        head_slot         = 0;
        tail_slot         = 0;
        held_words        = 0;
        error_count       = 0;
        commands_sent     = 0;
        results_seen      = 0;
        full_drops_seen   = 0;
        empty_pops_seen   = 0;
        idle_cycles       = 0;
        sender_gaps_on    = 1'b1;
        burst_left        = 0;
        hold_request      = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_ends();
        test_fill_to_full();
        test_drain_to_empty();
        test_output_hold_off();
        test_random_mix();

        settle_queue();
        repeat (5) @(posedge clk);
        $display("Sent %0d commands and checked %0d responses, including %0d pushes on full",
                 commands_sent, results_seen, full_drops_seen);
        $display("and %0d pops on empty, with both ends wrapping around the ring.",
                 empty_pops_seen);
        if (error_count == 0)
            $display("tb_double_ended_queue_top: clean");
        else
            $display("tb_double_ended_queue_top: errors");
        $finish;
    end

endmodule

// File: sim.f
design/dq_pkg.sv
design/dq_cmd_if.sv
design/dq_rsp_if.sv
design/dq_cell.sv
design/double_ended_queue_top.sv
tb/tb_double_ended_queue_top.sv
